### rtl/ablend_pkg.sv
// Shared types and constants for the alpha blend pipeline.
`default_nettype none

package ablend_pkg;

	// default sample width of the top level
	localparam int SAMPLE_BITS_DEF = 16;

	// raw alpha code and decoded weight widths
	localparam int ALPHA_BITS  = 17;
	localparam int WEIGHT_BITS = 17;

	// the denominator is 2^16 or 2^16 - 1
	localparam int DEN_SHIFT = 16;

	// alpha decoding modes, as written to the mode register
	typedef enum logic [1:0] {
		MODE_SELECT = 2'd0,
		MODE_BYTE   = 2'd1,
		MODE_SHORT  = 2'd2,
		MODE_FRAC   = 2'd3
	} alpha_mode_t;

	localparam alpha_mode_t MODE_RESET = MODE_BYTE;

	// weight of one in the power-of-two denominator
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;

	// rounding offsets (half denominator) and the odd denominator
	localparam logic [16:0] HALF_ODD  = 17'd32767;
	localparam logic [16:0] HALF_EVEN = 17'd32768;
	localparam logic [16:0] DEN_ODD   = 17'd65535;

	// side info handed to the divide stages
	typedef struct packed {
		logic neg;  // numerator was negative, result is negated
		logic odd;  // denominator is 2^16 - 1 rather than 2^16
	} div_ctl_t;

endpackage

`default_nettype wire

### rtl/alpha_blend_int16_multimode.sv
// Alpha blend top level: mode register, weight decode, product and rounding stages.
//
// Blends one sample of each of two images as first*(1-r) + second*r, exact,
// with negative sums truncated toward zero and other sums rounded half up.
// Input channel: in_valid / in_stall with first_sample, second_sample and
// alpha_code; a word is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with blended_sample.
// Mode register: cfg_valid / cfg_ready / cfg_data, always ready; write it
// only while the pipeline is empty. It selects one-bit, byte, signed short
// or Q1.16 alpha decoding.
// One word per clock is sustained while out_stall is low. The eight register
// stages are: decode, multiply, numerator sum, rounding offset, three folds
// of the divide by 2^16 - 1, and the final correction with sign restore.
// Reset clears every valid bit and sets the mode to byte alpha.
// While out_stall is high the held result stays put, empty stages keep
// filling, and in_stall rises only when all eight stages hold a word.
`default_nettype none

module alpha_blend_int16_multimode
	import ablend_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] first_sample,
	input  logic signed [SAMPLE_BITS-1:0] second_sample,
	input  logic [ALPHA_BITS-1:0]         alpha_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] blended_sample
);

	localparam int SB = SAMPLE_BITS;
	localparam int DW = SB + 1;
	localparam int PW = DW + WEIGHT_BITS + 1;
	localparam int NW = SB + DEN_SHIFT + 1;
	localparam int YW = SB + DEN_SHIFT;

	alpha_mode_t alpha_mode_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic div_ready;

	logic signed [SB-1:0]    a_s1;
	logic signed [DW-1:0]    diff_s1;
	logic [WEIGHT_BITS-1:0]  w_s1;
	logic                    odd_s1, odd_s2, odd_s3, odd_s4;
	logic signed [PW-1:0]    prod_s2;
	logic signed [NW-1:0]    ad_s2;
	logic [NW-1:0]           num_s3;
	logic [YW-1:0]           y_s4;
	logic                    neg_s4;

	logic [WEIGHT_BITS-1:0]  w_d;
	logic                    odd_d;
	logic signed [DW-1:0]    diff_d;
	logic signed [PW-1:0]    prod_d;
	logic signed [NW-1:0]    a_ext;
	logic signed [NW-1:0]    ad_d;
	logic signed [PW-1:0]    num_full;
	logic                    neg_d;
	logic [NW-1:0]           off_d;
	logic [NW-1:0]           ysum;
	div_ctl_t                div_ctl;

	// mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_mode_q <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_mode_q <= alpha_mode_t'(cfg_data);
		end
	end

	// ready chain, stage 4 feeds the divide unit
	assign rdy_s4   = !v_s4 || div_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1: weight decode; byte alpha is scaled by 257 onto 2^16 - 1
	always_comb begin
		w_d   = '0;
		odd_d = 1'b0;
		case (alpha_mode_q)
			MODE_SELECT: begin
				w_d   = {alpha_code[0], {DEN_SHIFT{1'b0}}};
				odd_d = 1'b0;
			end
			MODE_BYTE: begin
				w_d   = {1'b0, alpha_code[7:0], alpha_code[7:0]};
				odd_d = 1'b1;
			end
			MODE_SHORT: begin
				w_d   = {1'b0, ~alpha_code[15], alpha_code[14:0]};
				odd_d = 1'b1;
			end
			MODE_FRAC: begin
				w_d   = alpha_code[16] ? WEIGHT_ONE : alpha_code;
				odd_d = 1'b0;
			end
			default: begin
				w_d   = '0;
				odd_d = 1'b0;
			end
		endcase
	end

	assign diff_d = $signed({second_sample[SB-1], second_sample})
		- $signed({first_sample[SB-1], first_sample});

	// stage 2: (second - first) * w and first * D
	assign prod_d = diff_s1 * $signed({1'b0, w_s1});
	assign a_ext  = $signed({{(NW-SB){a_s1[SB-1]}}, a_s1});
	assign ad_d   = (a_ext <<< DEN_SHIFT) - (odd_s1 ? a_ext : '0);

	// stage 3: numerator
	assign num_full = $signed({{(PW-NW){ad_s2[NW-1]}}, ad_s2}) + prod_s2;

	// stage 4: magnitude plus rounding offset in one add
	assign neg_d = num_s3[NW-1];
	assign off_d = neg_d ? NW'(1) : (odd_s3 ? NW'(HALF_ODD) : NW'(HALF_EVEN));
	assign ysum  = (neg_d ? ~num_s3 : num_s3) + off_d;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			a_s1    <= first_sample;
			diff_s1 <= diff_d;
			w_s1    <= w_d;
			odd_s1  <= odd_d;
		end
		if (rdy_s2) begin
			prod_s2 <= prod_d;
			ad_s2   <= ad_d;
			odd_s2  <= odd_s1;
		end
		if (rdy_s3) begin
			num_s3 <= num_full[NW-1:0];
			odd_s3 <= odd_s2;
		end
		if (rdy_s4) begin
			y_s4   <= ysum[YW-1:0];
			neg_s4 <= neg_d;
			odd_s4 <= odd_s3;
		end
	end

	assign div_ctl.neg = neg_s4;
	assign div_ctl.odd = odd_s4;

	// stages 5 to 8: constant divide and sign restore
	ablend_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (v_s4),
		.req_ready (div_ready),
		.req_y     (y_s4),
		.req_ctl   (div_ctl),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res_data  (blended_sample)
	);

endmodule

`default_nettype wire

### rtl/ablend_div.sv
// Pipelined divide by 2^16 or 2^16 - 1 with sign restore (stages 5 to 8).
`default_nettype none

module ablend_div
	import ablend_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [SAMPLE_BITS+15:0]       req_y,
	input  div_ctl_t                      req_ctl,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic signed [SAMPLE_BITS-1:0] res_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int YW = SB + DEN_SHIFT;
	localparam int HW = YW - DEN_SHIFT;
	localparam int XW = ((SB > DEN_SHIFT) ? SB : DEN_SHIFT) + 1;
	localparam int QW = SB + 1;
	localparam int FW = XW - DEN_SHIFT;

	logic v_s5, v_s6, v_s7, v_s8;
	logic rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	logic [XW-1:0] x_s5, x_s6, x_s7;
	logic [QW-1:0] q_s5, q_s6, q_s7;
	logic          neg_s5, neg_s6, neg_s7;
	logic [SB-1:0] res_s8;

	logic [HW-1:0] h5;
	logic [XW-1:0] x5_d;
	logic [FW-1:0] h6, h7;
	logic [XW-1:0] x6_d, x7_d;
	logic          inc8;
	logic [QW-1:0] sum8;

	// bubble-collapsing ready chain
	assign rdy_s8    = !v_s8 || !res_stall;
	assign rdy_s7    = !v_s7 || rdy_s8;
	assign rdy_s6    = !v_s6 || rdy_s7;
	assign rdy_s5    = !v_s5 || rdy_s6;
	assign req_ready = rdy_s5;

	// first fold: y = h*2^16 + l gives q = h and remainder h + l for 2^16 - 1
	assign h5   = req_y[YW-1:DEN_SHIFT];
	assign x5_d = req_ctl.odd ? (XW'(h5) + XW'(req_y[DEN_SHIFT-1:0])) : '0;

	// second and third folds
	assign h6   = x_s5[XW-1:DEN_SHIFT];
	assign x6_d = XW'(h6) + XW'(x_s5[DEN_SHIFT-1:0]);
	assign h7   = x_s6[XW-1:DEN_SHIFT];
	assign x7_d = XW'(h7) + XW'(x_s6[DEN_SHIFT-1:0]);

	// last correction, then negate: -(q + inc) = ~q + 1 - inc
	assign inc8 = (x_s7 >= XW'(DEN_ODD));
	assign sum8 = (neg_s7 ? ~q_s7 : q_s7)
		+ (neg_s7 ? {{(QW-1){1'b0}}, ~inc8} : {{(QW-1){1'b0}}, inc8});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= req_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			x_s5   <= x5_d;
			q_s5   <= QW'(h5);
			neg_s5 <= req_ctl.neg;
		end
		if (rdy_s6) begin
			x_s6   <= x6_d;
			q_s6   <= q_s5 + QW'(h6);
			neg_s6 <= neg_s5;
		end
		if (rdy_s7) begin
			x_s7   <= x7_d;
			q_s7   <= q_s6 + QW'(h7);
			neg_s7 <= neg_s6;
		end
		if (rdy_s8) begin
			res_s8 <= sum8[SB-1:0];
		end
	end

	assign res_valid = v_s8;
	assign res_data  = $signed(res_s8);

endmodule

`default_nettype wire

### rtl/ablend_chk.sv
// Port-level checker for the alpha blend block, bound to the top level.
`default_nettype none

module ablend_chk
	import ablend_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] blended_sample
);

	// a held result word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a held result word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(blended_sample))
		else $error("blended_sample changed while stalled");

	// input backs up only when the output side is full and stalled
	a_in_stall_cause: assert property (@(posedge clk)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output word");

	// reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> (!out_valid && !in_stall))
		else $error("pipeline not empty in reset");

endmodule

bind alpha_blend_int16_multimode ablend_chk #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_ablend_chk (.*);

`default_nettype wire
